/* rtl/core/grc_pkg.sv */
package grc_pkg;

   localparam int CW = 40;
   localparam int VW = 49;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic wr_bit;
      logic rd_en;
   } map_ctl_type;

endpackage

/* rtl/core/grid_ray_cast.sv */
// Channel   Ports                                   Direction  Handshake
// request   start, busy, req_*                      in         start & !busy
// response  rsp_strobe, rsp_distance, rsp_no_hit    out        one-cycle strobe
// config    csr_wr_en, csr_index, csr_wdata         in         write on csr_wr_en
//
// A cast first forms ten products on the shared 32x32 multiplier (each in an
// S_MUL state, then an S_ACC state), then passes one setup state. It then walks
// the cells, with a map read and then a test and step for each cell, and on a hit
// computes the two squares, the bit-serial square root and the scaling. Walks are
// bounded by the map side. Reset is synchronous and clears control and the
// configuration registers, not the map. The response cannot be stalled.
module grid_ray_cast #(
   parameter int MAP_SIDE_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [15:0] req_cell_index,
   input  logic signed [7:0]  req_cell_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_dir_cos,
   input  logic signed [15:0] req_dir_sin,
   output logic        rsp_strobe,
   output logic [31:0] rsp_distance,
   output logic        rsp_no_hit,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CW    = grc_pkg::CW;
   localparam int VW    = grc_pkg::VW;
   localparam int DEPTH = MAP_SIDE_MAX * MAP_SIDE_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAP_SIDE_MAX);
   localparam int SW    = $clog2(MAP_SIDE_MAX + 1);
   localparam int RWW   = IW + SW;

   typedef enum logic [2:0] {
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_CELLS_PER_METER, REG_CELL_SIZE,
      REG_MAX_RANGE, REG_MAP_WIDTH, REG_MAP_HEIGHT, REG_NONE
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_ACC, S_SETUP, S_CHECK, S_TEST, S_ROOT
   } state_type;

   typedef enum logic [2:0] {
      OP_COS, OP_SIN, OP_CELL_LO, OP_CELL_HI, OP_SQ_A, OP_SQ_B, OP_SCALE
   } op_type;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [31:0] cells_per_meter_ff, cell_size_ff, max_range_ff;
   logic [8:0]  map_width_ff, map_height_ff;

   state_type state_ff;
   op_type    op_ff;
   logic [1:0] sel_ff;
   logic signed [15:0] dir_cos_ff, dir_sin_ff;
   logic signed [VW-1:0] v_ff [4];
   logic signed [CW-1:0] cell_ff [4];
   logic [63:0] prod_ff;
   logic [31:0] acc_ff;
   logic signed [CW-1:0] a_ff, b_ff, a0_ff, b0_ff, a1_ff, err_ff;
   logic [CW-1:0] da_ff, db_ff;
   logic up_a_ff, up_b_ff, steep_ff, off_ff;
   logic [31:0] off_a_ff, off_b_ff;
   logic [63:0] rad_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [4:0]  root_cnt_ff;
   logic        rsp_strobe_ff, rsp_no_hit_ff;
   logic [31:0] rsp_distance_ff;

   logic accept;
   logic [31:0] mul_a, mul_b;
   logic signed [VW-1:0] cur_v, cur_neg_v;
   logic [47:0] cur_mag;
   logic [15:0] cos_mag, sin_mag;
   logic signed [VW-1:0] dir_term;
   logic [VW-1:0] cell_sum;
   logic [34:0] cell_mag;
   logic signed [CW-1:0] cell_val;
   logic signed [CW-1:0] diff_a, diff_b;
   logic [CW-1:0] abs_a, abs_b;
   logic setup_steep;
   logic signed [CW-1:0] col, row;
   logic [SW-1:0] w_lim, h_lim;
   logic [RWW-1:0] row_w;
   logic [AW-1:0] rd_addr, wr_addr;
   logic off;
   logic hit;
   logic signed [CW-1:0] err_n, walk_da, walk_db;
   logic signed [CW:0] err_twice;
   logic [34:0] rem_n, trial;
   logic root_ge;
   logic [31:0] sq_sum;
   logic [47:0] scaled;
   logic signed [32:0] dx, dy;
   grc_pkg::map_ctl_type map_ctl;
   logic map_bit;

   assign accept = start & (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff        <= '0;
         origin_y_ff        <= '0;
         cells_per_meter_ff <= 32'd1310720;
         cell_size_ff       <= 32'd3277;
         max_range_ff       <= 32'd1638400;
         map_width_ff       <= 9'd256;
         map_height_ff      <= 9'd256;
      end else if (csr_wr_en) begin
         unique case (reg_type'(csr_index))
            REG_ORIGIN_X:        origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y:        origin_y_ff <= csr_wdata;
            REG_CELLS_PER_METER: cells_per_meter_ff <= csr_wdata;
            REG_CELL_SIZE:       cell_size_ff <= csr_wdata;
            REG_MAX_RANGE:       max_range_ff <= csr_wdata;
            REG_MAP_WIDTH:       map_width_ff <= csr_wdata[8:0];
            REG_MAP_HEIGHT:      map_height_ff <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cos_mag   = dir_cos_ff[15] ? 16'(-dir_cos_ff) : 16'(dir_cos_ff);
      sin_mag   = dir_sin_ff[15] ? 16'(-dir_sin_ff) : 16'(dir_sin_ff);
      cur_v     = v_ff[sel_ff];
      cur_neg_v = -cur_v;
      cur_mag   = cur_v[VW-1] ? cur_neg_v[47:0] : cur_v[47:0];

      unique case (op_ff)
         OP_COS: begin
            mul_a = max_range_ff;
            mul_b = 32'(cos_mag);
         end
         OP_SIN: begin
            mul_a = max_range_ff;
            mul_b = 32'(sin_mag);
         end
         OP_CELL_LO: begin
            mul_a = cur_mag[31:0];
            mul_b = cells_per_meter_ff;
         end
         OP_CELL_HI: begin
            mul_a = 32'(cur_mag[47:32]);
            mul_b = cells_per_meter_ff;
         end
         OP_SQ_A: begin
            mul_a = off_a_ff;
            mul_b = off_a_ff;
         end
         OP_SQ_B: begin
            mul_a = off_b_ff;
            mul_b = off_b_ff;
         end
         OP_SCALE: begin
            mul_a = root_ff;
            mul_b = cell_size_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      if ((op_ff == OP_COS && dir_cos_ff[15]) || (op_ff == OP_SIN && dir_sin_ff[15])) begin
         dir_term = -$signed({1'b0, prod_ff[47:0]});
      end else begin
         dir_term = $signed({1'b0, prod_ff[47:0]});
      end

      cell_sum = VW'(prod_ff[47:0]) + VW'(acc_ff);
      cell_mag = cell_sum[48:14];
      cell_val = cur_v[VW-1] ? -$signed(CW'(cell_mag)) : $signed(CW'(cell_mag));

      diff_a      = cell_ff[2] - cell_ff[0];
      diff_b      = cell_ff[3] - cell_ff[1];
      abs_a       = diff_a[CW-1] ? CW'(-diff_a) : CW'(diff_a);
      abs_b       = diff_b[CW-1] ? CW'(-diff_b) : CW'(diff_b);
      setup_steep = abs_a < abs_b;

      w_lim = (32'(map_width_ff) > 32'(MAP_SIDE_MAX)) ? SW'(MAP_SIDE_MAX) : SW'(map_width_ff);
      h_lim = (32'(map_height_ff) > 32'(MAP_SIDE_MAX)) ? SW'(MAP_SIDE_MAX) : SW'(map_height_ff);
      col   = steep_ff ? b_ff : a_ff;
      row   = steep_ff ? a_ff : b_ff;
      off   = col[CW-1] | row[CW-1] | (col >= $signed(CW'(w_lim)))
            | (row >= $signed(CW'(h_lim)));
      row_w   = RWW'(row[IW-1:0]) * RWW'(w_lim);
      rd_addr = AW'(row_w) + AW'(col[IW-1:0]);
      wr_addr = AW'(req_cell_index);
      hit     = off_ff | map_bit;

      walk_da   = $signed(da_ff);
      walk_db   = $signed(db_ff);
      err_n     = err_ff + walk_db;
      err_twice = {err_n, 1'b0};

      rem_n   = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      root_ge = rem_n >= trial;

      sq_sum = acc_ff + prod_ff[31:0];
      scaled = prod_ff[63:16];

      dx = $signed({req_pos_x[31], req_pos_x}) - $signed({origin_x_ff[31], origin_x_ff});
      dy = $signed({req_pos_y[31], req_pos_y}) - $signed({origin_y_ff[31], origin_y_ff});

      map_ctl.wr_en  = accept & (req_opcode == grc_pkg::OP_WRITE)
                     & (32'(req_cell_index) < 32'(DEPTH));
      map_ctl.wr_bit = (req_cell_value != 8'sd0);
      map_ctl.rd_en  = (state_ff == S_CHECK);
   end

   always_ff @(posedge clock) begin
      rsp_strobe_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_COS;
         sel_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_opcode == grc_pkg::OP_CAST) begin
                  dir_cos_ff <= req_dir_cos;
                  dir_sin_ff <= req_dir_sin;
                  v_ff[0]    <= {{2{dx[32]}}, dx, 14'b0};
                  v_ff[1]    <= {{2{dy[32]}}, dy, 14'b0};
                  op_ff      <= OP_COS;
                  sel_ff     <= '0;
                  state_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               state_ff <= S_MUL;
               unique case (op_ff)
                  OP_COS: begin
                     v_ff[2] <= v_ff[0] + dir_term;
                     op_ff   <= OP_SIN;
                  end
                  OP_SIN: begin
                     v_ff[3] <= v_ff[1] + dir_term;
                     op_ff   <= OP_CELL_LO;
                     sel_ff  <= '0;
                  end
                  OP_CELL_LO: begin
                     acc_ff <= prod_ff[63:32];
                     op_ff  <= OP_CELL_HI;
                  end
                  OP_CELL_HI: begin
                     cell_ff[sel_ff] <= cell_val;
                     op_ff           <= OP_CELL_LO;
                     sel_ff          <= sel_ff + 2'd1;
                     if (sel_ff == 2'd3) begin
                        state_ff <= S_SETUP;
                     end
                  end
                  OP_SQ_A: begin
                     acc_ff <= prod_ff[31:0];
                     op_ff  <= OP_SQ_B;
                  end
                  OP_SQ_B: begin
                     rad_ff      <= {sq_sum, 32'b0};
                     rem_ff      <= '0;
                     root_ff     <= '0;
                     root_cnt_ff <= 5'd31;
                     state_ff    <= S_ROOT;
                  end
                  OP_SCALE: begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_no_hit_ff   <= 1'b0;
                     rsp_distance_ff <= (scaled[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                                  : scaled[31:0];
                     state_ff        <= S_IDLE;
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
            S_SETUP: begin
               steep_ff <= setup_steep;
               err_ff   <= '0;
               if (setup_steep) begin
                  a0_ff   <= cell_ff[1];
                  b0_ff   <= cell_ff[0];
                  a_ff    <= cell_ff[1];
                  b_ff    <= cell_ff[0];
                  a1_ff   <= cell_ff[3];
                  da_ff   <= abs_b;
                  db_ff   <= abs_a;
                  up_a_ff <= ~diff_b[CW-1] & (diff_b != '0);
                  up_b_ff <= ~diff_a[CW-1] & (diff_a != '0);
               end else begin
                  a0_ff   <= cell_ff[0];
                  b0_ff   <= cell_ff[1];
                  a_ff    <= cell_ff[0];
                  b_ff    <= cell_ff[1];
                  a1_ff   <= cell_ff[2];
                  da_ff   <= abs_a;
                  db_ff   <= abs_b;
                  up_a_ff <= ~diff_a[CW-1] & (diff_a != '0);
                  up_b_ff <= ~diff_b[CW-1] & (diff_b != '0);
               end
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               off_ff   <= off;
               state_ff <= S_TEST;
            end
            S_TEST: begin
               priority if (hit) begin
                  off_a_ff <= 32'(a_ff - a0_ff);
                  off_b_ff <= 32'(b_ff - b0_ff);
                  op_ff    <= OP_SQ_A;
                  state_ff <= S_MUL;
               end else if (a_ff == a1_ff) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_no_hit_ff   <= 1'b1;
                  rsp_distance_ff <= max_range_ff;
                  state_ff        <= S_IDLE;
               end else begin
                  a_ff <= up_a_ff ? a_ff + CW'(1) : a_ff - CW'(1);
                  if (err_twice >= $signed({walk_da[CW-1], walk_da})) begin
                     b_ff   <= up_b_ff ? b_ff + CW'(1) : b_ff - CW'(1);
                     err_ff <= err_n - walk_da;
                  end else begin
                     err_ff <= err_n;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_ROOT: begin
               rem_ff      <= root_ge ? rem_n - trial : rem_n;
               root_ff     <= {root_ff[30:0], root_ge};
               rad_ff      <= {rad_ff[61:0], 2'b00};
               root_cnt_ff <= root_cnt_ff - 5'd1;
               if (root_cnt_ff == 5'd0) begin
                  op_ff    <= OP_SCALE;
                  state_ff <= S_MUL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   grc_map #(
      .MAP_SIDE_MAX (MAP_SIDE_MAX)
   ) u_map (
      .clock   (clock),
      .ctl     (map_ctl),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (map_bit)
   );

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_no_hit   = rsp_no_hit_ff;

endmodule

/* rtl/core/grc_map.sv */
module grc_map #(
   parameter int MAP_SIDE_MAX = 256
) (
   input  logic                                            clock,
   input  grc_pkg::map_ctl_type                            ctl,
   input  logic [$clog2(MAP_SIDE_MAX*MAP_SIDE_MAX)-1:0]    wr_addr,
   input  logic [$clog2(MAP_SIDE_MAX*MAP_SIDE_MAX)-1:0]    rd_addr,
   output logic                                            rd_data
);

   localparam int DEPTH = MAP_SIDE_MAX * MAP_SIDE_MAX;

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_bit;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/grid_ray_cast_tb.sv */
`timescale 1ns / 1ps

module grid_ray_cast_tb;

   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] REG_CELLS_PER_M = 3'd2;
   localparam logic [2:0] REG_CELL_SIZE  = 3'd3;
   localparam logic [2:0] REG_MAX_RANGE  = 3'd4;
   localparam logic [2:0] REG_MAP_WIDTH  = 3'd5;
   localparam logic [2:0] REG_MAP_HEIGHT = 3'd6;
   localparam logic [2:0] REG_UNUSED     = 3'd7;
   localparam int         SIDE_MAX       = 256;

   typedef struct {
      logic [31:0] distance;
      logic        no_hit;
   } range_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [15:0] req_cell_index;
   logic signed [7:0]  req_cell_value;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [15:0] req_dir_cos;
   logic signed [15:0] req_dir_sin;
   logic        rsp_strobe;
   logic [31:0] rsp_distance;
   logic        rsp_no_hit;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   bit          occupied [0:65535];
   bit          written [0:65535];
   logic signed [31:0] map_ox, map_oy;
   logic [31:0] cells_per_m, cell_len, ray_len;
   logic [8:0]  map_w, map_h;

   range_type   range_q[$];
   range_type   got;
   int          fails;
   int          idle_pct;

   grid_ray_cast u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_cell_index(req_cell_index),
      .req_cell_value(req_cell_value), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_dir_cos(req_dir_cos), .req_dir_sin(req_dir_sin),
      .rsp_strobe(rsp_strobe), .rsp_distance(rsp_distance), .rsp_no_hit(rsp_no_hit),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint cell_of(longint q);
      longint unsigned mag, lo, hi, sum;
      longint c;
      mag = (q < 0) ? longint'(-q) : q;
      lo = mag & 64'hFFFF_FFFF;
      hi = mag >> 32;
      sum = hi * longint'(cells_per_m) + ((lo * longint'(cells_per_m)) >> 32);
      c = longint'(sum >> 14);
      return (q < 0) ? -c : c;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void cast_predict(input logic signed [31:0] px, input logic signed [31:0] py,
                                        input logic signed [15:0] dc, input logic signed [15:0] ds,
                                        output range_type res, output bit unsafe);
      longint rx, ry, a0, b0, a1, b1, da, db, a, b, sa, sb, err, t, col, row, w, h, idx;
      longint unsigned s, r, d;
      bit steep, hit;
      unsafe = 0;
      rx = (longint'(px) - longint'(map_ox)) * 16384;
      ry = (longint'(py) - longint'(map_oy)) * 16384;
      a0 = cell_of(rx);
      b0 = cell_of(ry);
      a1 = cell_of(rx + longint'(ray_len) * longint'(dc));
      b1 = cell_of(ry + longint'(ray_len) * longint'(ds));
      da = (a1 > a0) ? a1 - a0 : a0 - a1;
      db = (b1 > b0) ? b1 - b0 : b0 - b1;
      steep = da < db;
      if (steep) begin
         t = a0; a0 = b0; b0 = t;
         t = a1; a1 = b1; b1 = t;
         t = da; da = db; db = t;
      end
      sa = (a1 > a0) ? 1 : -1;
      sb = (b1 > b0) ? 1 : -1;
      a = a0;
      b = b0;
      err = 0;
      w = (map_w > SIDE_MAX) ? SIDE_MAX : map_w;
      h = (map_h > SIDE_MAX) ? SIDE_MAX : map_h;
      forever begin
         col = steep ? b : a;
         row = steep ? a : b;
         if (col < 0 || col >= w || row < 0 || row >= h) begin
            hit = 1;
         end else begin
            idx = row * w + col;
            if (!written[idx]) unsafe = 1;
            hit = occupied[idx];
         end
         if (hit) begin
            s = longint'((a - a0) * (a - a0)) + longint'((b - b0) * (b - b0));
            r = int_sqrt(s << 32);
            d = (r * longint'(cell_len)) >> 16;
            res.distance = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
            res.no_hit = 1'b0;
            return;
         end
         if (a == a1) break;
         a = a + sa;
         err = err + db;
         if (2 * err >= da) begin
            b = b + sb;
            err = err - da;
         end
      end
      res.distance = ray_len;
      res.no_hit = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (range_q.size() == 0) begin
            $error("unexpected result: distance %0d no_hit %0d", rsp_distance, rsp_no_hit);
            fails++;
         end else begin
            got = range_q.pop_front();
            if (rsp_distance !== got.distance) begin
               $error("distance: expected %0d, got %0d", got.distance, rsp_distance);
               fails++;
            end
            if (rsp_no_hit !== got.no_hit) begin
               $error("no_hit: expected %0d, got %0d", got.no_hit, rsp_no_hit);
               fails++;
            end
         end
      end
   end

   task automatic send_item(input logic op, input logic [15:0] idx, input logic signed [7:0] val,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [15:0] dc, input logic signed [15:0] ds);
      range_type res;
      bit unsafe;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_cell_index <= idx;
      req_cell_value <= val;
      req_pos_x <= px;
      req_pos_y <= py;
      req_dir_cos <= dc;
      req_dir_sin <= ds;
      do @(posedge clock); while (busy);
      if (op == grc_pkg::OP_WRITE) begin
         occupied[idx] = (val != 0);
         written[idx] = 1'b1;
      end else begin
         cast_predict(px, py, dc, ds, res, unsafe);
         range_q.push_back(res);
      end
   endtask

   task automatic write_cell(input logic [15:0] idx, input logic signed [7:0] val);
      send_item(grc_pkg::OP_WRITE, idx, val, 32'($urandom), 32'($urandom),
                16'($urandom), 16'($urandom));
   endtask

   task automatic cast_ray(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [15:0] dc, input logic signed [15:0] ds);
      range_type res;
      bit unsafe;
      cast_predict(px, py, dc, ds, res, unsafe);
      if (!unsafe) send_item(grc_pkg::OP_CAST, 16'($urandom), 8'($urandom), px, py, dc, ds);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (range_q.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         REG_ORIGIN_X:    map_ox = value;
         REG_ORIGIN_Y:    map_oy = value;
         REG_CELLS_PER_M: cells_per_m = value;
         REG_CELL_SIZE:   cell_len = value;
         REG_MAX_RANGE:   ray_len = value;
         REG_MAP_WIDTH:   map_w = value[8:0];
         REG_MAP_HEIGHT:  map_h = value[8:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_map(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] cpm,
                          input logic [31:0] csz, input logic [31:0] mr,
                          input logic [31:0] w, input logic [31:0] h);
      drain();
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_CELLS_PER_M, cpm);
      write_reg(REG_CELL_SIZE, csz);
      write_reg(REG_MAX_RANGE, mr);
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_HEIGHT, h);
      write_reg(REG_UNUSED, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int map_cells();
      int w, h;
      w = (map_w > SIDE_MAX) ? SIDE_MAX : map_w;
      h = (map_h > SIDE_MAX) ? SIDE_MAX : map_h;
      return w * h;
   endfunction

   function automatic logic signed [7:0] random_occupancy();
      if ($urandom_range(99) < 80) return 8'sd0;
      return ($urandom_range(1) != 0) ? -8'sd1 : 8'($urandom_range(1, 255));
   endfunction

   task automatic fill_map;
      for (int i = 0; i < map_cells(); i++) write_cell(16'(i), random_occupancy());
   endtask

   function automatic logic signed [31:0] pos_in(input int c, input logic signed [31:0] org);
      longint unsigned off;
      off = ((longint'(c) << 32) + longint'($urandom)) / longint'(cells_per_m);
      return org + off[31:0];
   endfunction

   task automatic random_items(input int n);
      int w, h;
      logic signed [15:0] dc, ds;
      w = (map_w > SIDE_MAX) ? SIDE_MAX : ((map_w == 0) ? 1 : map_w);
      h = (map_h > SIDE_MAX) ? SIDE_MAX : ((map_h == 0) ? 1 : map_h);
      repeat (n) begin
         dc = 16'($signed($urandom_range(32768)) - 16384);
         ds = 16'($signed($urandom_range(32768)) - 16384);
         if ($urandom_range(9) == 0) begin
            dc = ($urandom_range(1) != 0) ? 16'sd16384 : -16'sd16384;
            ds = '0;
         end
         case ($urandom_range(19))
            0, 1, 2, 3: write_cell(16'((map_cells() > 0) ? $urandom_range(map_cells() - 1) : 0),
                                   random_occupancy());
            4: write_cell(16'($urandom), 8'($urandom));
            5, 6: cast_ray(32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom));
            default: cast_ray(pos_in($urandom_range(w - 1), map_ox),
                              pos_in($urandom_range(h - 1), map_oy), dc, ds);
         endcase
         if ($urandom_range(199) == 0) drain();
      end
   endtask

   task automatic test_directed;
      idle_pct = 0;
      set_map(0, 0, 32'h0004_0000, 32'h0000_4000, 32'h0004_0000, 16, 16);
      fill_map();
      write_cell(8 * 16 + 8, 8'sd0);
      write_cell(16'hFFFF, -8'sd128);
      write_cell(16'h0000, 8'sd127);
      write_cell(16'h0000, 8'sd0);
      cast_ray(32'h0002_2000, 32'h0002_2000, 16'sd16384, 16'sd0);
      cast_ray(32'h0002_2000, 32'h0002_2000, -16'sd16384, 16'sd0);
      cast_ray(32'h0002_2000, 32'h0002_2000, 16'sd0, 16'sd16384);
      cast_ray(32'h0002_2000, 32'h0002_2000, 16'sd0, -16'sd16384);
      cast_ray(32'h0002_2000, 32'h0002_2000, 16'sd11585, 16'sd11585);
      cast_ray(32'h0002_2000, 32'h0002_2000, -16'sd11585, 16'sd4000);
      cast_ray(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384, 16'sd16384);
      cast_ray(32'h8000_0000, 32'h7FFF_FFFF, -16'sd16384, -16'sd16384);
      write_cell(8 * 16 + 8, -8'sd1);
      cast_ray(32'h0002_2000, 32'h0002_2000, 16'sd16384, 16'sd0);
   endtask

   task automatic test_tiny_maps;
      idle_pct = 0;
      set_map(0, 0, 32'h0001_0000, 1, 0, 1, 1);
      write_cell(0, 8'sd0);
      cast_ray(32'h0000_8000, 32'h0000_8000, 16'sd16384, 16'sd0);
      write_cell(0, -8'sd1);
      cast_ray(32'h0000_8000, 32'h0000_8000, 16'sd16384, 16'sd0);
      set_map(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h000A_0000, 0, 0);
      cast_ray(32'h0000_8000, 32'h0000_8000, 16'sd16384, 16'sd0);
      random_items(20);
      set_map(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h000A_0000, 300, 511);
      cast_ray(32'h0000_8000, 32'h0000_8000, -16'sd16384, 16'sd0);
      cast_ray(32'h0000_8000, 32'h0000_8000, 16'sd0, -16'sd16384);
   endtask

   task automatic test_random_phases;
      idle_pct = 0;
      set_map(0, 0, 32'h0004_0000, 32'h0000_4000, 32'h0004_0000, 16, 16);
      random_items(165);
      idle_pct = 76;
      set_map(32'hFFFB_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0014_0000, 32, 8);
      fill_map();
      random_items(165);
      idle_pct = 76;
      set_map(32'h0000_8000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_6666, 32'h0010_0000, 12, 40);
      fill_map();
      random_items(165);
      idle_pct = 11;
      set_map(0, 0, 32'h0004_0000, 32'h0000_4000, 32'h0004_0000, 16, 16);
      random_items(165);
   endtask

   task automatic test_extremes;
      idle_pct = 0;
      set_map(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              256, 256);
      random_items(60);
      set_map(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0, 256, 256);
      random_items(40);
      set_map(0, 0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16, 16);
      random_items(60);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = grc_pkg::OP_WRITE;
      req_cell_index = '0;
      req_cell_value = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_dir_cos = '0;
      req_dir_sin = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fails = 0;
      idle_pct = 0;
      map_ox = 0;
      map_oy = 0;
      cells_per_m = 32'd1310720;
      cell_len = 32'd3277;
      ray_len = 32'd1638400;
      map_w = 9'd256;
      map_h = 9'd256;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tiny_maps();
      test_random_phases();
      test_extremes();
      drain();
      repeat (20) @(posedge clock);
      if (fails == 0 && range_q.size() == 0) begin
         $display("grid_ray_cast_tb OK");
      end else begin
         $display("grid_ray_cast_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("grid_ray_cast_tb NOT OK");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/grc_pkg.sv
rtl/core/grc_map.sv
rtl/core/grid_ray_cast.sv
test/grid_ray_cast_tb.sv
